FILE: rtl/core/tccw_pkg.sv
// ----------------------------------------------------------------------------
// tccw_pkg
// shared widths, character codes, register indexes and result type for the
// text console cursor writer
// ----------------------------------------------------------------------------
package tccw_pkg;

   localparam int COL_W  = 7;
   localparam int ROW_W  = 5;
   localparam int CHAR_W = 8;
   localparam int ATTR_W = 8;
   localparam int TAB_W  = 5;
   localparam int CSR_W  = 8;
   localparam int IDX_W  = 1;

   localparam int DEFAULT_SCREEN_COLUMNS = 80;
   localparam int DEFAULT_SCREEN_ROWS    = 25;

   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
   localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

   localparam logic [ATTR_W-1:0] TEXT_ATTRIBUTE_RESET = 8'h07;
   localparam logic [TAB_W-1:0]  TAB_STEP_RESET       = 5'd4;

   localparam logic [IDX_W-1:0] CSR_TEXT_ATTRIBUTE = 1'd0;
   localparam logic [IDX_W-1:0] CSR_TAB_STEP       = 1'd1;

   typedef struct packed {
      logic [ROW_W-1:0]  row;
      logic [COL_W-1:0]  column;
      logic [CHAR_W-1:0] character;
      logic [ATTR_W-1:0] attribute;
      logic              scroll;
   } cell_type;

endpackage

FILE: rtl/core/tccw_cursor.sv
// ----------------------------------------------------------------------------
// tccw_cursor
// next cursor position and written cell for one character
// ----------------------------------------------------------------------------
module tccw_cursor #(
   parameter int SCREEN_COLUMNS = tccw_pkg::DEFAULT_SCREEN_COLUMNS,
   parameter int SCREEN_ROWS    = tccw_pkg::DEFAULT_SCREEN_ROWS
) (
   input  logic [tccw_pkg::CHAR_W-1:0] character,
   input  logic [tccw_pkg::COL_W-1:0]  column,
   input  logic [tccw_pkg::ROW_W-1:0]  row,
   input  logic [tccw_pkg::TAB_W-1:0]  tab_step,
   input  logic [tccw_pkg::ATTR_W-1:0] attribute,
   output logic [tccw_pkg::COL_W-1:0]  column_next,
   output logic [tccw_pkg::ROW_W-1:0]  row_next,
   output logic                        has_cell,
   output tccw_pkg::cell_type          wr_cell
);
   import tccw_pkg::*;

   localparam logic [COL_W-1:0] COLS     = COL_W'(SCREEN_COLUMNS);
   localparam logic [ROW_W-1:0] ROWS     = ROW_W'(SCREEN_ROWS);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_ROWS - 1);

   logic [ROW_W-1:0]  row_adv;
   logic [COL_W:0]    tab_sum;
   logic [COL_W-1:0]  col_step;
   logic [COL_W-1:0]  col_wr;
   logic [ROW_W-1:0]  row_wr;
   logic              back;
   logic              scroll;

   always_comb begin
      row_adv  = (row < ROWS) ? row + 1'b1 : ROWS;
      tab_sum  = {1'b0, column} + {{(COL_W+1-TAB_W){1'b0}}, tab_step};
      back     = (character == CH_BACKSPACE);
      col_step = column;
      if (back && column != '0) begin
         col_step = column - 1'b1;
      end
      col_wr = col_step;
      row_wr = row;
      if (col_step >= COLS) begin
         col_wr = '0;
         row_wr = row_adv;
      end
      scroll = (row_wr >= ROWS);
      if (scroll) begin
         row_wr = LAST_ROW;
      end

      wr_cell.row       = row_wr;
      wr_cell.column    = col_wr;
      wr_cell.character = back ? CH_SPACE : character;
      wr_cell.attribute = attribute;
      wr_cell.scroll    = scroll;

      unique case (character)
         CH_NEWLINE: begin
            has_cell    = 1'b0;
            row_next    = row_adv;
            column_next = '0;
         end
         CH_TAB: begin
            has_cell    = 1'b0;
            row_next    = row;
            column_next = (tab_sum > {1'b0, COLS}) ? COLS : tab_sum[COL_W-1:0];
         end
         default: begin
            has_cell    = 1'b1;
            row_next    = row_wr;
            column_next = back ? col_wr : col_wr + 1'b1;
         end
      endcase
   end

endmodule

FILE: rtl/core/tccw_out_queue.sv
// ----------------------------------------------------------------------------
// tccw_out_queue
// two-entry result queue, decouples the result ready from the input side
// ----------------------------------------------------------------------------
module tccw_out_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  tccw_pkg::cell_type push_cell,
   output logic               full,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output tccw_pkg::cell_type rsp_cell
);
   import tccw_pkg::*;

   cell_type   entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       pop;

   always_comb begin
      pop       = rsp_valid && rsp_ready;
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_cell;
      end
   end

   assign full      = (count_ff == 2'd2);
   assign rsp_valid = (count_ff != 2'd0);
   assign rsp_cell  = entry_ff[rd_ptr_ff];

endmodule

FILE: rtl/core/text_console_cursor_writer.sv
// ----------------------------------------------------------------------------
// text_console_cursor_writer
// path: an accepted item goes to the input register, then the cursor update
// pushes its cell, if any, into a two-entry result queue (held while full)
// throughput: one item per cycle unless held, set by the cursor update loop
// reset: cursor to row 0 column 0, attribute 0x07, tab step 4, queue empty
// ----------------------------------------------------------------------------
module text_console_cursor_writer #(
   parameter int SCREEN_COLUMNS = tccw_pkg::DEFAULT_SCREEN_COLUMNS,
   parameter int SCREEN_ROWS    = tccw_pkg::DEFAULT_SCREEN_ROWS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        req_valid,
   output logic                        req_ready,
   input  logic [tccw_pkg::CHAR_W-1:0] req_character,
   output logic                        rsp_valid,
   input  logic                        rsp_ready,
   output logic [tccw_pkg::ROW_W-1:0]  rsp_cell_row,
   output logic [tccw_pkg::COL_W-1:0]  rsp_cell_column,
   output logic [tccw_pkg::CHAR_W-1:0] rsp_cell_character,
   output logic [tccw_pkg::ATTR_W-1:0] rsp_cell_attribute,
   output logic                        rsp_scroll_first,
   input  logic                        csr_write_enable,
   input  logic [tccw_pkg::IDX_W-1:0]  csr_index,
   input  logic [tccw_pkg::CSR_W-1:0]  csr_write_data
);
   import tccw_pkg::*;

   localparam logic [COL_W-1:0] COLS     = COL_W'(SCREEN_COLUMNS);
   localparam logic [ROW_W-1:0] ROWS     = ROW_W'(SCREEN_ROWS);
   localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(SCREEN_ROWS - 1);

   logic              in_valid_ff, in_valid_in;
   logic [CHAR_W-1:0] in_char_ff;
   logic [COL_W-1:0]  column_ff, column_in;
   logic [ROW_W-1:0]  row_ff, row_in;
   logic [ATTR_W-1:0] attribute_ff;
   logic [TAB_W-1:0]  tab_step_ff;
   logic              has_cell;
   cell_type          wr_cell;
   cell_type          rsp_cell;
   logic              queue_full;
   logic              advance;
   logic              push;
   logic              accept;

   tccw_cursor #(
      .SCREEN_COLUMNS(SCREEN_COLUMNS),
      .SCREEN_ROWS   (SCREEN_ROWS)
   ) u_cursor (
      .character  (in_char_ff),
      .column     (column_ff),
      .row        (row_ff),
      .tab_step   (tab_step_ff),
      .attribute  (attribute_ff),
      .column_next(column_in),
      .row_next   (row_in),
      .has_cell   (has_cell),
      .wr_cell    (wr_cell)
   );

   tccw_out_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cell(wr_cell),
      .full     (queue_full),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_cell (rsp_cell)
   );

   always_comb begin
      advance     = in_valid_ff && !(has_cell && queue_full);
      push        = advance && has_cell;
      req_ready   = !in_valid_ff || advance;
      accept      = req_valid && req_ready;
      in_valid_in = accept || (in_valid_ff && !advance);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         column_ff    <= '0;
         row_ff       <= '0;
         attribute_ff <= TEXT_ATTRIBUTE_RESET;
         tab_step_ff  <= TAB_STEP_RESET;
      end else begin
         in_valid_ff <= in_valid_in;
         if (advance) begin
            column_ff <= column_in;
            row_ff    <= row_in;
         end
         if (csr_write_enable) begin
            unique case (csr_index)
               CSR_TEXT_ATTRIBUTE: attribute_ff <= csr_write_data[ATTR_W-1:0];
               CSR_TAB_STEP:       tab_step_ff  <= csr_write_data[TAB_W-1:0];
               default: begin
               end
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         in_char_ff <= req_character;
      end
   end

   assign rsp_cell_row       = rsp_cell.row;
   assign rsp_cell_column    = rsp_cell.column;
   assign rsp_cell_character = rsp_cell.character;
   assign rsp_cell_attribute = rsp_cell.attribute;
   assign rsp_scroll_first   = rsp_cell.scroll;

   // cursor stays within the screen plus the wrap and pending-scroll marks
   a_cursor_range: assert property (@(posedge clock) disable iff (reset)
      (column_ff <= COLS) && (row_ff <= ROWS))
      else $error("cursor out of range");

   // a scroll always writes the bottom row
   a_scroll_row: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_scroll_first) |-> (rsp_cell_row == LAST_ROW))
      else $error("scroll with wrong row");

   // a written cell lies on the screen
   a_cell_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_cell_column < COLS) && (rsp_cell_row < ROWS)))
      else $error("cell off screen");

   // a held item with a cell never overruns a full queue
   a_no_overrun: assert property (@(posedge clock) disable iff (reset)
      (in_valid_ff && has_cell && queue_full) |=> in_valid_ff)
      else $error("item lost on full queue");

endmodule
